@@ hw/rtl/ltbc_pkg.sv @@
// ltbc_pkg: shared widths, blend mode codes and transfer types for the
// layered texture blend compositor. No dependencies.
`default_nettype none

package ltbc_pkg;

  // fixed point format
  localparam int FRAC_BITS = 12;
  localparam int FIELD_W   = FRAC_BITS + 1;
  localparam int ACC_W     = FRAC_BITS + 7;
  localparam int MODE_W    = 4;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int HALF      = ONE >> 1;
  localparam int FIELD_MAX = (1 << FIELD_W) - 1;
  localparam int ACC_MAX   = (1 << (ACC_W - 1)) - 1;
  localparam int ACC_MIN   = -(1 << (ACC_W - 1));

  // colour lane datapath widths
  localparam int XA_W = ACC_W + 1;           // first multiplier, left operand
  localparam int YA_W = FRAC_BITS + 2;       // alpha or one minus alpha
  localparam int PA_W = XA_W + YA_W;
  localparam int MA_W = PA_W - FRAC_BITS;
  localparam int PB_W = ACC_W + YA_W;
  localparam int MB_W = PB_W - FRAC_BITS;
  localparam int F_W  = FRAC_BITS + 5;       // second multiplier factor
  localparam int PC_W = ACC_W + F_W;
  localparam int MC_W = PC_W - FRAC_BITS;
  localparam int R_W  = MC_W + 1;            // blend sum before saturation

  // alpha lane datapath widths
  localparam int AB_W  = FIELD_W + 1;
  localparam int PAL_W = AB_W + YA_W;
  localparam int AR_W  = PAL_W - FRAC_BITS;

  // blend mode codes
  localparam logic [MODE_W-1:0] MODE_NONE       = 4'd0;
  localparam logic [MODE_W-1:0] MODE_OVER       = 4'd1;
  localparam logic [MODE_W-1:0] MODE_IN         = 4'd2;
  localparam logic [MODE_W-1:0] MODE_OUT        = 4'd3;
  localparam logic [MODE_W-1:0] MODE_ADD        = 4'd4;
  localparam logic [MODE_W-1:0] MODE_SUBTRACT   = 4'd5;
  localparam logic [MODE_W-1:0] MODE_MULTIPLY   = 4'd6;
  localparam logic [MODE_W-1:0] MODE_DIFFERENCE = 4'd7;
  localparam logic [MODE_W-1:0] MODE_LIGHTEN    = 4'd8;
  localparam logic [MODE_W-1:0] MODE_DARKEN     = 4'd9;
  localparam logic [MODE_W-1:0] MODE_SATURATE   = 4'd10;
  localparam logic [MODE_W-1:0] MODE_DESATURATE = 4'd11;
  localparam logic [MODE_W-1:0] MODE_ILLUMINATE = 4'd12;

  // output_kind register values
  localparam logic KIND_COLOR = 1'b0;
  localparam logic KIND_ALPHA = 1'b1;

  typedef struct packed {
    logic [FIELD_W-1:0] layer_red;
    logic [FIELD_W-1:0] layer_green;
    logic [FIELD_W-1:0] layer_blue;
    logic [FIELD_W-1:0] layer_alpha;
    logic [MODE_W-1:0]  blend_mode;
    logic               layer_visible;
    logic               last_layer;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] out_red;
    logic [FIELD_W-1:0] out_green;
    logic [FIELD_W-1:0] out_blue;
    logic [FIELD_W-1:0] out_alpha;
    logic               no_layers;
  } out_item_t;

  // control from the sequencer to every lane
  typedef struct packed {
    logic capture;   // load stage one from the live layer
    logic update;    // commit the accumulator this cycle
    logic visible;   // layer in stage two takes part
    logic restart;   // layer in stage two ends the pixel
  } lane_ctrl_t;

  typedef enum logic {
    ST_IDLE,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/ltbc_color_lane.sv @@
// ltbc_color_lane: one colour channel of the compositor, two multiply
// stages and the running channel accumulator. Depends on ltbc_pkg.
`default_nettype none

module ltbc_color_lane import ltbc_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire lane_ctrl_t              ctrl,
  input  wire logic [FIELD_W-1:0]      chan_in,
  input  wire logic [FIELD_W-1:0]      alpha_in,
  input  wire logic [MODE_W-1:0]       mode_in,
  output logic signed [ACC_W-1:0]      result
);

  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [FIELD_W-1:0]      c_r, a_r;
  logic [MODE_W-1:0]       mode_r;
  logic signed [MA_W-1:0]  ma_r;
  logic signed [MB_W-1:0]  mb_r;

  // stage one operands
  logic signed [XA_W-1:0]  b_x, c_x, diff_x, absdiff_x, xa;
  logic signed [YA_W-1:0]  a_s, inv_s, ya;
  logic signed [ACC_W-1:0] b_s;
  logic signed [PA_W-1:0]  pa, pa_rnd;
  logic signed [PB_W-1:0]  pb, pb_rnd;

  assign b_s       = acc_r;
  assign b_x       = XA_W'(acc_r);
  assign c_x       = XA_W'({1'b0, chan_in});
  assign diff_x    = c_x - b_x;
  assign absdiff_x = (diff_x < 0) ? -diff_x : diff_x;
  assign a_s       = YA_W'({1'b0, alpha_in});
  assign inv_s     = YA_W'(ONE) - a_s;

  // first multiplier operand selection
  always_comb begin
    xa = b_x;
    ya = a_s;
    case (mode_in)
      MODE_OVER:       xa = diff_x;
      MODE_IN:         xa = b_x;
      MODE_OUT: begin
        xa = b_x;
        ya = inv_s;
      end
      MODE_ADD, MODE_SUBTRACT, MODE_MULTIPLY,
      MODE_SATURATE, MODE_DESATURATE: xa = c_x;
      MODE_DIFFERENCE: xa = absdiff_x;
      MODE_LIGHTEN:    xa = (c_x > b_x) ? c_x : b_x;
      MODE_DARKEN:     xa = (c_x < b_x) ? c_x : b_x;
      MODE_ILLUMINATE: xa = c_x + c_x;
      default:         xa = b_x;
    endcase
  end

  // stage one products, rounded to nearest
  assign pa     = xa * ya;
  assign pa_rnd = pa + PA_W'(HALF);
  assign pb     = b_s * inv_s;
  assign pb_rnd = pb + PB_W'(HALF);

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      c_r    <= chan_in;
      a_r    <= alpha_in;
      mode_r <= mode_in;
      ma_r   <= pa_rnd[PA_W-1:FRAC_BITS];
      mb_r   <= pb_rnd[PB_W-1:FRAC_BITS];
    end
  end

  // stage two: second factor and product
  logic signed [F_W-1:0]  t_f, a_f, inv_f, f_c;
  logic signed [PC_W-1:0] pc, pc_rnd;
  logic signed [MC_W-1:0] mc;

  assign t_f   = $signed(ma_r[F_W-1:0]);
  assign a_f   = F_W'({1'b0, a_r});
  assign inv_f = F_W'(ONE) - a_f;

  always_comb begin
    case (mode_r)
      MODE_SATURATE:   f_c = F_W'(ONE) + t_f;
      MODE_DESATURATE: f_c = F_W'(ONE) - t_f;
      default:         f_c = t_f + inv_f;
    endcase
  end

  assign pc     = b_s * f_c;
  assign pc_rnd = pc + PC_W'(HALF);
  assign mc     = pc_rnd[PC_W-1:FRAC_BITS];

  // stage two: blend sum and saturation
  logic signed [R_W-1:0]   b_w, c_w, ma_w, mb_w, mc_w, r_w;
  logic signed [ACC_W-1:0] blended;

  assign b_w  = R_W'(acc_r);
  assign c_w  = R_W'({1'b0, c_r});
  assign ma_w = R_W'(ma_r);
  assign mb_w = R_W'(mb_r);
  assign mc_w = R_W'(mc);

  always_comb begin
    case (mode_r)
      MODE_NONE:       r_w = c_w;
      MODE_OVER:       r_w = b_w + ma_w;
      MODE_IN:         r_w = ma_w;
      MODE_OUT:        r_w = mb_w;
      MODE_ADD:        r_w = b_w + ma_w;
      MODE_SUBTRACT:   r_w = b_w - ma_w;
      MODE_MULTIPLY, MODE_SATURATE,
      MODE_DESATURATE, MODE_ILLUMINATE: r_w = mc_w;
      MODE_DIFFERENCE, MODE_LIGHTEN,
      MODE_DARKEN:     r_w = ma_w + mb_w;
      default:         r_w = b_w;
    endcase
  end

  always_comb begin
    if (r_w > R_W'(ACC_MAX)) begin
      blended = ACC_W'(ACC_MAX);
    end else if (r_w < R_W'(ACC_MIN)) begin
      blended = ACC_W'(ACC_MIN);
    end else begin
      blended = r_w[ACC_W-1:0];
    end
  end

  assign result = ctrl.visible ? blended : acc_r;

  // accumulator, back to black at the end of a pixel
  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.update) begin
      acc_nxt = ctrl.restart ? '0 : result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ltbc_alpha_lane.sv @@
// ltbc_alpha_lane: running alpha of the compositor, one multiply stage and
// the alpha accumulator. Depends on ltbc_pkg.
`default_nettype none

module ltbc_alpha_lane import ltbc_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire lane_ctrl_t          ctrl,
  input  wire logic [FIELD_W-1:0]  alpha_in,
  input  wire logic [MODE_W-1:0]   mode_in,
  output logic [FIELD_W-1:0]       result
);

  logic [FIELD_W-1:0]     acc_r, acc_nxt;
  logic [FIELD_W-1:0]     a_r;
  logic [MODE_W-1:0]      mode_r;
  logic signed [AR_W-1:0] mq_r;

  // stage one: running alpha times alpha or one minus alpha
  logic signed [AB_W-1:0]  b_s;
  logic signed [YA_W-1:0]  a_s, inv_s, y_s;
  logic signed [PAL_W-1:0] pq, pq_rnd;

  assign b_s    = AB_W'({1'b0, acc_r});
  assign a_s    = YA_W'({1'b0, alpha_in});
  assign inv_s  = YA_W'(ONE) - a_s;
  assign y_s    = (mode_in == MODE_OUT) ? inv_s : a_s;
  assign pq     = b_s * y_s;
  assign pq_rnd = pq + PAL_W'(HALF);

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      a_r    <= alpha_in;
      mode_r <= mode_in;
      mq_r   <= pq_rnd[PAL_W-1:FRAC_BITS];
    end
  end

  // stage two: alpha blend and saturation to the field range
  logic signed [AR_W-1:0] b_w, a_w, r_w;
  logic [FIELD_W-1:0]     blended;

  assign b_w = AR_W'({1'b0, acc_r});
  assign a_w = AR_W'({1'b0, a_r});

  always_comb begin
    case (mode_r)
      MODE_NONE: r_w = a_w;
      MODE_OVER: r_w = b_w + a_w - mq_r;
      MODE_IN:   r_w = mq_r;
      MODE_OUT:  r_w = mq_r;
      default:   r_w = b_w;
    endcase
  end

  always_comb begin
    if (r_w < 0) begin
      blended = '0;
    end else if (r_w > AR_W'(FIELD_MAX)) begin
      blended = FIELD_W'(FIELD_MAX);
    end else begin
      blended = r_w[FIELD_W-1:0];
    end
  end

  assign result = ctrl.visible ? blended : acc_r;

  // accumulator, back to one at the end of a pixel
  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.update) begin
      acc_nxt = ctrl.restart ? FIELD_W'(ONE) : result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= FIELD_W'(ONE);
    end else begin
      acc_r <= acc_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ltbc_merge.sv @@
// ltbc_merge: combines the four lane results into one result item, with
// colour clamping and output selection. Depends on ltbc_pkg.
`default_nettype none

module ltbc_merge import ltbc_pkg::*; (
  input  wire logic signed [ACC_W-1:0] red,
  input  wire logic signed [ACC_W-1:0] green,
  input  wire logic signed [ACC_W-1:0] blue,
  input  wire logic [FIELD_W-1:0]      alpha,
  input  wire logic                    any_visible,
  input  wire logic                    output_kind,
  output out_item_t                    item
);

  function automatic logic [FIELD_W-1:0] clamp_unit(input logic signed [ACC_W-1:0] v);
    logic [FIELD_W-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > ACC_W'(ONE)) begin
      res = FIELD_W'(ONE);
    end else begin
      res = v[FIELD_W-1:0];
    end
    return res;
  endfunction

  // pick colour or alpha, all zero when nothing was visible
  always_comb begin
    item = '0;
    item.no_layers = !any_visible;
    if (any_visible) begin
      if (output_kind == KIND_COLOR) begin
        item.out_red   = clamp_unit(red);
        item.out_green = clamp_unit(green);
        item.out_blue  = clamp_unit(blue);
      end else begin
        item.out_alpha = alpha;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/layered_texture_blend_compositor_unit.sv @@
// A last layer's result is loaded into the output register when the layer leaves the second stage.
// Layers are taken one at a time; each layer passes the two multiply stages of
// the colour lanes (the second product depends on the first) before the next is taken.
// A last layer waits in the second stage while the output register is still full.
// Reset (rst_n low, synchronous): colour to black, alpha to one, no layer seen,
// output_kind to colour, output register empty. Depends on ltbc_pkg and the lanes.
`default_nettype none

module layered_texture_blend_compositor_unit import ltbc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic      cfg_data
);

  state_t     state_r, state_nxt;
  logic       vis_r, last_r, any_vis_r, any_vis_nxt;
  logic       kind_r;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r, merged;
  logic       capture, advance, update, load;
  lane_ctrl_t ctrl;

  // config register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= KIND_COLOR;
    end else if (cfg_valid) begin
      kind_r <= cfg_data;
    end
  end

  // second stage holds a last layer until the output register frees up
  assign advance = !(last_r && out_valid_r && !out_ready);

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_FIN;
      ST_FIN:  if (advance) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    capture  = 1'b0;
    update   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        capture  = in_valid;
      end
      ST_FIN: update = advance;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign load = update && last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // per layer flags carried into stage two
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vis_r  <= 1'b0;
      last_r <= 1'b0;
    end else if (capture) begin
      vis_r  <= in_data.layer_visible;
      last_r <= in_data.last_layer;
    end
  end

  // visible layer seen in this pixel
  always_comb begin
    any_vis_nxt = any_vis_r;
    if (update) begin
      any_vis_nxt = last_r ? 1'b0 : (any_vis_r | vis_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_vis_r <= 1'b0;
    end else begin
      any_vis_r <= any_vis_nxt;
    end
  end

  assign ctrl = '{capture: capture, update: update, visible: vis_r, restart: last_r};

  // lanes
  logic signed [ACC_W-1:0] red_res, green_res, blue_res;
  logic [FIELD_W-1:0]      alpha_res;

  ltbc_color_lane u_red (
    .clk(clk), .rst_n(rst_n), .ctrl(ctrl),
    .chan_in(in_data.layer_red), .alpha_in(in_data.layer_alpha),
    .mode_in(in_data.blend_mode), .result(red_res)
  );

  ltbc_color_lane u_green (
    .clk(clk), .rst_n(rst_n), .ctrl(ctrl),
    .chan_in(in_data.layer_green), .alpha_in(in_data.layer_alpha),
    .mode_in(in_data.blend_mode), .result(green_res)
  );

  ltbc_color_lane u_blue (
    .clk(clk), .rst_n(rst_n), .ctrl(ctrl),
    .chan_in(in_data.layer_blue), .alpha_in(in_data.layer_alpha),
    .mode_in(in_data.blend_mode), .result(blue_res)
  );

  ltbc_alpha_lane u_alpha (
    .clk(clk), .rst_n(rst_n), .ctrl(ctrl),
    .alpha_in(in_data.layer_alpha), .mode_in(in_data.blend_mode),
    .result(alpha_res)
  );

  // merge lane results into one item
  ltbc_merge u_merge (
    .red(red_res), .green(green_res), .blue(blue_res), .alpha(alpha_res),
    .any_visible(any_vis_r | vis_r), .output_kind(kind_r), .item(merged)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= merged;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_accept_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_FIN))
    else $error("accepted layer did not enter second stage");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!out_valid_r || out_ready))
    else $error("result loaded over a pending transfer");

  a_pixel_restart: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> !any_vis_r)
    else $error("visible flag not cleared after last layer");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.no_layers) |->
      (out_data.out_red == '0 && out_data.out_green == '0 &&
       out_data.out_blue == '0 && out_data.out_alpha == '0))
    else $error("empty pixel carries nonzero values");

  a_kind_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.out_alpha != '0) |->
      (out_data.out_red == '0 && out_data.out_green == '0 &&
       out_data.out_blue == '0))
    else $error("colour and alpha both present in result");

endmodule

`default_nettype wire

@@ tb/sv/tb_layered_texture_blend_compositor_unit.sv @@
// tb_layered_texture_blend_compositor_unit: self-checking bench for the layer compositor,
// a transfer-level predictor fed by a queued layer driver and an output monitor.
// Depends on ltbc_pkg and layered_texture_blend_compositor_unit.
`timescale 1ns / 100ps

module tb_layered_texture_blend_compositor_unit;
  import ltbc_pkg::*;

  // codes past the last defined blend mode
  localparam logic [MODE_W-1:0] MODE_UNUSED_TOP = 4'd15;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_CYCLES  = 120;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data = 1'b0;

  layered_texture_blend_compositor_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // layers waiting to go out, composited pixels waiting to come back
  in_item_t  layer_q[$];
  out_item_t composited_q[$];
  int        queued_layers = 0;
  int        taken_layers = 0;
  int        err_cnt = 0;
  logic      layer_taken = 1'b0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  logic      stall_go = 1'b0;

  // predictor state
  logic signed [ACC_W-1:0] acc_r = '0;
  logic signed [ACC_W-1:0] acc_g = '0;
  logic signed [ACC_W-1:0] acc_b = '0;
  logic [FIELD_W-1:0]      acc_a = FIELD_W'(ONE);
  logic                    seen_visible = 1'b0;
  logic                    out_kind = KIND_COLOR;

  initial begin
    forever #6 clk = ~clk;
  end

  // fixed point product, rounded half up
  function automatic longint qmul(longint x, longint y);
    return (x * y + HALF) >>> FRAC_BITS;
  endfunction

  function automatic longint sat(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint blend_channel(longint b, longint c, longint a,
                                           logic [MODE_W-1:0] mode);
    longint inv;
    longint r;
    inv = ONE - a;
    case (mode)
      MODE_NONE:       r = c;
      MODE_OVER:       r = b + qmul(c - b, a);
      MODE_IN:         r = qmul(b, a);
      MODE_OUT:        r = qmul(b, inv);
      MODE_ADD:        r = b + qmul(c, a);
      MODE_SUBTRACT:   r = b - qmul(c, a);
      MODE_MULTIPLY:   r = qmul(qmul(c, a) + inv, b);
      MODE_DIFFERENCE: r = qmul((c > b) ? c - b : b - c, a) + qmul(b, inv);
      MODE_LIGHTEN:    r = qmul((c > b) ? c : b, a) + qmul(inv, b);
      MODE_DARKEN:     r = qmul((c < b) ? c : b, a) + qmul(inv, b);
      MODE_SATURATE:   r = qmul(b, ONE + qmul(c, a));
      MODE_DESATURATE: r = qmul(b, ONE - qmul(c, a));
      MODE_ILLUMINATE: r = qmul(b, qmul(2 * c, a) + inv);
      default:         r = b;
    endcase
    return sat(r, ACC_MIN, ACC_MAX);
  endfunction

  function automatic longint blend_opacity(longint b, longint a, logic [MODE_W-1:0] mode);
    longint r;
    case (mode)
      MODE_NONE: r = a;
      MODE_OVER: r = b + a - qmul(b, a);
      MODE_IN:   r = qmul(b, a);
      MODE_OUT:  r = qmul(b, ONE - a);
      default:   r = b;
    endcase
    return sat(r, 0, FIELD_MAX);
  endfunction

  // fold one accepted layer into the running pixel, emit on the last one
  task automatic composite_layer(input in_item_t lyr);
    out_item_t px;
    if (lyr.layer_visible) begin
      acc_r = ACC_W'(blend_channel(acc_r, lyr.layer_red, lyr.layer_alpha, lyr.blend_mode));
      acc_g = ACC_W'(blend_channel(acc_g, lyr.layer_green, lyr.layer_alpha, lyr.blend_mode));
      acc_b = ACC_W'(blend_channel(acc_b, lyr.layer_blue, lyr.layer_alpha, lyr.blend_mode));
      acc_a = FIELD_W'(blend_opacity(acc_a, lyr.layer_alpha, lyr.blend_mode));
      seen_visible = 1'b1;
    end
    if (lyr.last_layer) begin
      px = '0;
      px.no_layers = !seen_visible;
      if (seen_visible) begin
        if (out_kind == KIND_COLOR) begin
          px.out_red   = FIELD_W'(sat(acc_r, 0, ONE));
          px.out_green = FIELD_W'(sat(acc_g, 0, ONE));
          px.out_blue  = FIELD_W'(sat(acc_b, 0, ONE));
        end else begin
          px.out_alpha = acc_a;
        end
      end
      composited_q.push_back(px);
      acc_r = '0;
      acc_g = '0;
      acc_b = '0;
      acc_a = FIELD_W'(ONE);
      seen_visible = 1'b0;
    end
  endtask

  task automatic check_pixel(input out_item_t got);
    out_item_t exp_px;
    if (composited_q.size() == 0) begin
      err_cnt++;
      if (err_cnt <= 10)
        $display("unexpected pixel r=%0d g=%0d b=%0d a=%0d empty=%0b", got.out_red,
                 got.out_green, got.out_blue, got.out_alpha, got.no_layers);
    end else begin
      exp_px = composited_q.pop_front();
      if (got.out_red !== exp_px.out_red || got.out_green !== exp_px.out_green ||
          got.out_blue !== exp_px.out_blue || got.out_alpha !== exp_px.out_alpha ||
          got.no_layers !== exp_px.no_layers) begin
        err_cnt++;
        if (err_cnt <= 10) begin
          $display("pixel mismatch: exp r=%0d g=%0d b=%0d a=%0d empty=%0b",
                   exp_px.out_red, exp_px.out_green, exp_px.out_blue, exp_px.out_alpha,
                   exp_px.no_layers);
          $display("                got r=%0d g=%0d b=%0d a=%0d empty=%0b",
                   got.out_red, got.out_green, got.out_blue, got.out_alpha,
                   got.no_layers);
        end
      end
    end
  endtask

  // monitor: transfers on both channels, sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      composite_layer(in_data);
      void'(layer_q.pop_front());
      layer_taken = 1'b1;
      taken_layers++;
    end
    if (rst_n && out_valid && out_ready)
      check_pixel(out_data);
  end

  // layer driver: hold until taken, then maybe idle
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !layer_taken) begin
      in_valid <= 1'b1;
    end else if (layer_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      in_valid <= 1'b1;
      in_data  <= layer_q[0];
    end else begin
      in_valid <= 1'b0;
    end
    layer_taken = 1'b0;
  end

  // result receiver with random back-pressure and an occasional long hold-off
  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_go) begin
      stall_left = STALL_CYCLES;
      stall_go = 1'b0;
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic in_item_t mk(int r, int g, int b, int a, logic [MODE_W-1:0] mode,
                                  logic vis, logic last);
    in_item_t lyr;
    lyr.layer_red     = FIELD_W'(r);
    lyr.layer_green   = FIELD_W'(g);
    lyr.layer_blue    = FIELD_W'(b);
    lyr.layer_alpha   = FIELD_W'(a);
    lyr.blend_mode    = mode;
    lyr.layer_visible = vis;
    lyr.last_layer    = last;
    return lyr;
  endfunction

  task automatic offer(input in_item_t lyr);
    layer_q.push_back(lyr);
    queued_layers++;
  endtask

  // channel levels biased to the edges of the range
  function automatic int rand_level();
    case ($urandom_range(9))
      0:       return 0;
      1:       return ONE;
      2:       return FIELD_MAX;
      3:       return ONE - 1;
      8, 9:    return $urandom_range(FIELD_MAX);
      default: return $urandom_range(ONE);
    endcase
  endfunction

  function automatic in_item_t rand_layer(logic last);
    in_item_t lyr;
    lyr = mk(rand_level(), rand_level(), rand_level(), rand_level(), MODE_NONE,
             ($urandom_range(99) < 88), last);
    if ($urandom_range(99) < 6)
      lyr.blend_mode = MODE_W'($urandom_range(MODE_UNUSED_TOP, MODE_ILLUMINATE + 1));
    else
      lyr.blend_mode = MODE_W'($urandom_range(MODE_ILLUMINATE, MODE_NONE));
    return lyr;
  endfunction

  // one pixel: mostly short mixed stacks, some long saturating runs, some all hidden
  task automatic push_random_pixel(output int n);
    int pick;
    logic [MODE_W-1:0] run_mode;
    in_item_t lyr;
    pick = $urandom_range(99);
    if (pick < 4) begin
      n = $urandom_range(40, 16);
      run_mode = $urandom_range(1) ? MODE_ADD : MODE_SUBTRACT;
      for (int i = 0; i < n; i++) begin
        lyr = rand_layer(i == n - 1);
        lyr.blend_mode    = run_mode;
        lyr.layer_visible = 1'b1;
        lyr.layer_alpha   = FIELD_W'(FIELD_MAX);
        if ($urandom_range(3) != 0) begin
          lyr.layer_red   = FIELD_W'(FIELD_MAX);
          lyr.layer_green = FIELD_W'(FIELD_MAX);
          lyr.layer_blue  = FIELD_W'(FIELD_MAX);
        end
        offer(lyr);
      end
    end else if (pick < 10) begin
      n = $urandom_range(3, 1);
      for (int i = 0; i < n; i++) begin
        lyr = rand_layer(i == n - 1);
        lyr.layer_visible = 1'b0;
        offer(lyr);
      end
    end else begin
      n = ($urandom_range(99) < 40) ? 1 : $urandom_range(6, 2);
      for (int i = 0; i < n; i++)
        offer(rand_layer(i == n - 1));
    end
  endtask

  // wait for every queued layer and every pixel, then let the pipeline settle
  task automatic drain();
    while (taken_layers != queued_layers || composited_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_output_kind(input logic kind);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= kind;
    do @(posedge clk); while (!cfg_ready);
    out_kind = kind;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input logic kind, input int snd, input int rcv, input int count);
    int made;
    int n;
    made = 0;
    write_output_kind(kind);
    send_idle_pct = snd;
    recv_idle_pct = rcv;
    while (made < count) begin
      push_random_pixel(n);
      made += n;
    end
    drain();
  endtask

  // main sequence
  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    write_output_kind(KIND_COLOR);
    send_idle_pct = 31;
    recv_idle_pct = 72;

    // one pixel through every blend mode, extreme alphas and values above one
    offer(mk(ONE, 0, FIELD_MAX, FIELD_MAX, MODE_NONE, 1'b1, 1'b0));
    offer(mk(2048, ONE, 0, 2048, MODE_OVER, 1'b1, 1'b0));
    offer(mk(0, 0, 0, 3000, MODE_IN, 1'b1, 1'b0));
    offer(mk(0, 0, 0, 1000, MODE_OUT, 1'b1, 1'b0));
    offer(mk(FIELD_MAX, 1234, ONE, ONE, MODE_ADD, 1'b1, 1'b0));
    offer(mk(ONE, FIELD_MAX, 1, FIELD_MAX, MODE_SUBTRACT, 1'b1, 1'b0));
    offer(mk(3000, 500, FIELD_MAX, 2500, MODE_MULTIPLY, 1'b1, 1'b0));
    offer(mk(100, 4000, 2048, ONE, MODE_DIFFERENCE, 1'b1, 1'b0));
    offer(mk(FIELD_MAX, 0, 4000, 1500, MODE_LIGHTEN, 1'b1, 1'b0));
    offer(mk(0, FIELD_MAX, 2000, 3500, MODE_DARKEN, 1'b1, 1'b0));
    offer(mk(ONE, 2000, FIELD_MAX, FIELD_MAX, MODE_SATURATE, 1'b1, 1'b0));
    offer(mk(1500, ONE, 0, 2222, MODE_DESATURATE, 1'b1, 1'b0));
    offer(mk(FIELD_MAX, 3000, 700, 0, MODE_ILLUMINATE, 1'b1, 1'b1));
    // unknown mode: visible but leaves black
    offer(mk(ONE, ONE, ONE, ONE, MODE_UNUSED_TOP, 1'b1, 1'b1));
    // hidden last layer on its own gives an empty pixel
    offer(mk(FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX, MODE_NONE, 1'b0, 1'b1));
    // hidden last layer still closes a visible pixel
    offer(mk(FIELD_MAX, ONE, 0, FIELD_MAX, MODE_ADD, 1'b1, 1'b0));
    offer(mk(0, 0, 0, 0, MODE_OVER, 1'b0, 1'b1));
    // negative colour clamps to zero
    offer(mk(FIELD_MAX, 0, ONE, FIELD_MAX, MODE_SUBTRACT, 1'b1, 1'b1));
    offer(mk(0, 0, 0, 0, MODE_NONE, 1'b1, 1'b1));
    offer(mk(ONE, ONE, ONE, FIELD_MAX, MODE_OUT, 1'b1, 1'b1));
    drain();

    // alpha selected: same corners for the opacity path
    write_output_kind(KIND_ALPHA);
    offer(mk(ONE, ONE, ONE, FIELD_MAX, MODE_OUT, 1'b1, 1'b1));
    offer(mk(0, 0, 0, FIELD_MAX, MODE_NONE, 1'b1, 1'b0));
    offer(mk(0, 0, 0, FIELD_MAX, MODE_OVER, 1'b1, 1'b1));
    offer(mk(0, 0, 0, 0, MODE_NONE, 1'b0, 1'b1));
    drain();

    run_random(KIND_ALPHA, 31, 72, 330);
    run_random(KIND_COLOR, 31, 72, 330);
    run_random(KIND_ALPHA, 72, 31, 330);
    run_random(KIND_COLOR, 72, 31, 330);
    run_random(KIND_ALPHA, 0, 0, 330);
    run_random(KIND_COLOR, 0, 0, 330);

    // long receiver hold-off while single-layer pixels keep coming
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk);
    stall_go = 1'b1;
    for (int i = 0; i < 40; i++)
      offer(rand_layer(1'b1));
    drain();

    if (err_cnt == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

endmodule
